>>> src/lsd_pkg.sv
// ----------------------------------------------------------------------------
// lsd_pkg: shared types and constants for the link stuck detector
// Request layouts, register indexes, reset values and the divide constants.
// ----------------------------------------------------------------------------
package lsd_pkg;

  localparam int unsigned TS_W     = 32;
  localparam int unsigned SECS_W   = 23;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_W-1:0] ARM_TIME_RST     = 32'd60000;
  localparam logic [CFG_W-1:0] TRIGGER_TIME_RST = 32'd900000;

  // Outage start value used when an outage begins at timestamp zero.
  localparam logic [TS_W-1:0] OUTAGE_FIX = 32'd1;

  // floor(x / 1000) == (x * DIV_MUL) >> DIV_SHIFT for every 32-bit x.
  localparam int unsigned DIV_SHIFT = 38;
  localparam int unsigned DIV_MUL_W = 29;
  localparam logic [DIV_MUL_W-1:0] DIV_MUL = 29'd274877907;
  localparam int unsigned PROD_W = TS_W + DIV_MUL_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ARM_TIME     = 1'b0,
    REG_TRIGGER_TIME = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic            network_up;
    logic            relay_up;
    logic [TS_W-1:0] now_millis;
  } in_req_t;

  typedef struct packed {
    logic              stuck;
    logic [SECS_W-1:0] outage_seconds;
  } out_req_t;

  // Tracker result handed to the seconds stage.
  typedef struct packed {
    logic            stuck;
    logic [TS_W-1:0] outage_ms;
  } trk_res_t;

endpackage

>>> src/lsd_tracker.sv
// ----------------------------------------------------------------------------
// lsd_tracker: link and outage state tracking
// Holds the link/outage state and computes stuck and outage length per request.
// ----------------------------------------------------------------------------
module lsd_tracker (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    step_en,
  input  lsd_pkg::in_req_t        req,
  input  logic [lsd_pkg::CFG_W-1:0] arm_time,
  input  logic [lsd_pkg::CFG_W-1:0] trigger_time,
  output lsd_pkg::trk_res_t       res
);
  import lsd_pkg::*;

  logic            link_held_r, link_held_nxt;
  logic            armed_r, armed_nxt;
  logic [TS_W-1:0] link_start_r, link_start_nxt;
  logic [TS_W-1:0] outage_start_r, outage_start_nxt;
  logic [TS_W-1:0] link_ms;
  logic [TS_W-1:0] outage_ms;

  always_comb begin
    link_held_nxt    = link_held_r;
    armed_nxt        = armed_r;
    link_start_nxt   = link_start_r;
    outage_start_nxt = outage_start_r;
    res.stuck        = 1'b0;
    if (!req.network_up) begin
      link_held_nxt    = 1'b0;
      link_start_nxt   = '0;
      outage_start_nxt = '0;
    end else if (req.relay_up) begin
      if (!link_held_r) begin
        link_held_nxt  = 1'b1;
        link_start_nxt = req.now_millis;
      end
      outage_start_nxt = '0;
    end else begin
      link_held_nxt  = 1'b0;
      link_start_nxt = link_held_r ? '0 : link_start_r;
      if (outage_start_r == '0) begin
        outage_start_nxt = (req.now_millis != '0) ? req.now_millis : OUTAGE_FIX;
      end
    end
    link_ms   = req.now_millis - link_start_nxt;
    outage_ms = req.now_millis - outage_start_nxt;
    if (req.network_up && req.relay_up && (link_ms >= arm_time)) begin
      armed_nxt = 1'b1;
    end
    if (req.network_up && !req.relay_up && armed_r && (outage_ms >= trigger_time)) begin
      res.stuck = 1'b1;
    end
    res.outage_ms = (outage_start_nxt != '0) ? outage_ms : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_held_r    <= 1'b0;
      armed_r        <= 1'b0;
      link_start_r   <= '0;
      outage_start_r <= '0;
    end else if (step_en) begin
      link_held_r    <= link_held_nxt;
      armed_r        <= armed_nxt;
      link_start_r   <= link_start_nxt;
      outage_start_r <= outage_start_nxt;
    end
  end

endmodule

>>> src/lsd_div1000.sv
// ----------------------------------------------------------------------------
// lsd_div1000: milliseconds to whole seconds
// Divides by 1000 through a reciprocal multiply and a fixed shift.
// ----------------------------------------------------------------------------
module lsd_div1000 (
  input  logic [lsd_pkg::TS_W-1:0]   ms,
  output logic [lsd_pkg::SECS_W-1:0] secs
);
  import lsd_pkg::*;

  logic [PROD_W-1:0] prod;

  assign prod = {{DIV_MUL_W{1'b0}}, ms} * {{TS_W{1'b0}}, DIV_MUL};
  assign secs = prod[DIV_SHIFT +: SECS_W];

endmodule

>>> src/link_stuck_detector.sv
// ----------------------------------------------------------------------------
// link_stuck_detector: relay link stuck detector
// Flags a device that stays on the network without its relay for too long.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one request per cycle while in_stall is
//   low: network_up, relay_up and a free-running millisecond timestamp.
//   out_valid/out_stall/out_data return exactly one result per request:
//   stuck and the whole seconds of the current relay outage.
//   cfg_we/cfg_index/cfg_data write arm_time_ms (index 0) and
//   trigger_time_ms (index 1); write only while the block is idle.
// Pipeline:
//   input register, state tracker into a result register, divide-by-1000
//   multiply into the output register, in that order; out_valid is the
//   output register's valid bit. One request per cycle unless out_stall
//   holds a waiting result.
// Reset:
//   Synchronous, active low. Clears the pipeline valid bits, the link and outage
//   state, the armed flag, and loads the default thresholds.
// Stall:
//   The pipeline advances as one; while out_stall holds a waiting result,
//   in_stall is raised and every stage holds.
// ----------------------------------------------------------------------------
module link_stuck_detector (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lsd_pkg::in_req_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lsd_pkg::out_req_t             out_data,
  input  logic                          cfg_we,
  input  logic [lsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lsd_pkg::CFG_W-1:0]     cfg_data
);
  import lsd_pkg::*;

  logic              advance;
  logic [CFG_W-1:0]  arm_time_r;
  logic [CFG_W-1:0]  trigger_time_r;

  // Stage 1: input register
  logic              s1_valid_r;
  in_req_t           s1_req_r;
  // Stage 2: tracker result
  logic              s2_valid_r;
  trk_res_t          trk_res;
  trk_res_t          s2_res_r;
  // Stage 3: output register
  logic              s3_valid_r;
  out_req_t          s3_req_r;
  logic [SECS_W-1:0] secs;

  // Move every stage together unless a finished result is held back.
  assign advance  = !(s3_valid_r && out_stall);
  assign in_stall = !advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      arm_time_r     <= ARM_TIME_RST;
      trigger_time_r <= TRIGGER_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ARM_TIME:     arm_time_r     <= cfg_data;
        REG_TRIGGER_TIME: trigger_time_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits: shift the pipeline when allowed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // Payload registers: no reset, load with the pipeline
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_req_r <= in_data;
      s2_res_r <= trk_res;
      s3_req_r <= '{stuck: s2_res_r.stuck, outage_seconds: secs};
    end
  end

  // Update the link/outage state once per request leaving stage 1.
  lsd_tracker u_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .step_en      (advance && s1_valid_r),
    .req          (s1_req_r),
    .arm_time     (arm_time_r),
    .trigger_time (trigger_time_r),
    .res          (trk_res)
  );

  // Convert outage length to whole seconds.
  lsd_div1000 u_div (
    .ms   (s2_res_r.outage_ms),
    .secs (secs)
  );

  assign out_valid = s3_valid_r;
  assign out_data  = s3_req_r;

endmodule
